/* design/stnl_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the nearest-symbol lookup block.
// No dependencies; every other design file refers to this package by scoped names.
package stnl_pkg;

    localparam int MAX_SYMBOLS = 1024;
    localparam int ADDR_W      = 64;
    localparam int NAME_W      = 32;
    localparam int COUNT_W     = $clog2(MAX_SYMBOLS + 1);
    localparam int TREE_LEVELS = $clog2(MAX_SYMBOLS);
    localparam int TREE_LEAVES = 1 << TREE_LEVELS;
    localparam int LAT_W       = $clog2(TREE_LEVELS + 2);

    // Request codes.
    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_ADD    = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_STORED   = 3'd0;
    localparam logic [2:0] ST_SKIPPED  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_FOUND    = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic [2:0] ST_CLEARED  = 3'd5;

    // Symbol type held in the low nibble of the info byte for a file symbol.
    localparam logic [3:0] SYM_TYPE_FILE = 4'd4;

    // What one cell offers to the gather tree during a lookup.
    typedef struct packed {
        logic              hit;
        logic              beyond;
        logic [ADDR_W-1:0] addr;
        logic [NAME_W-1:0] name;
    } leaf_t;

endpackage

/* design/stnl_cell.sv */
`timescale 1ns / 1ps
// One cell of the sorted symbol chain: holds one address and name offset.
// Depends on stnl_pkg.
module stnl_cell
(
    input  logic                        clk,
    input  logic [stnl_pkg::ADDR_W-1:0] key,
    input  logic [stnl_pkg::NAME_W-1:0] name_new,
    input  logic                        ins_en,
    input  logic                        valid,
    input  logic                        prev_le,
    input  logic [stnl_pkg::ADDR_W-1:0] prev_addr,
    input  logic [stnl_pkg::NAME_W-1:0] prev_name,
    input  logic                        next_le,
    input  logic                        next_valid,
    output logic                        le,
    output logic [stnl_pkg::ADDR_W-1:0] addr,
    output logic [stnl_pkg::NAME_W-1:0] name,
    output stnl_pkg::leaf_t             leaf
);

    logic [stnl_pkg::ADDR_W-1:0] addr_reg;
    logic [stnl_pkg::ADDR_W-1:0] addr_next;
    logic [stnl_pkg::NAME_W-1:0] name_reg;
    logic [stnl_pkg::NAME_W-1:0] name_next;

    assign le   = valid & (addr_reg <= key);
    assign addr = addr_reg;
    assign name = name_reg;

    // An entry that sorts after the key moves one place up; the first such
    // cell takes the new entry, so equal keys keep their arrival order.
    always_comb
    begin
        addr_next = addr_reg;
        name_next = name_reg;
        if (ins_en && !le)
        begin
            if (prev_le)
            begin
                addr_next = key;
                name_next = name_new;
            end
            else
            begin
                addr_next = prev_addr;
                name_next = prev_name;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        name_reg <= name_next;
    end

    // This cell is the floor when it is the last one at or below the key.
    always_comb
    begin
        leaf.hit    = le & ~next_le;
        leaf.beyond = le & ~next_le & ~next_valid & (addr_reg != key);
        leaf.addr   = leaf.hit ? addr_reg : '0;
        leaf.name   = leaf.hit ? name_reg : '0;
    end

endmodule

/* design/stnl_tree.sv */
`timescale 1ns / 1ps
// Registered OR tree that gathers the single hitting cell's entry.
// Depends on stnl_pkg.
module stnl_tree
(
    input  logic            clk,
    input  stnl_pkg::leaf_t leaf [stnl_pkg::MAX_SYMBOLS],
    output stnl_pkg::leaf_t root
);

    stnl_pkg::leaf_t node_reg [1:2*stnl_pkg::TREE_LEAVES-1];

    genvar gi;
    generate
        for (gi = 0; gi < stnl_pkg::TREE_LEAVES; gi++)
        begin : g_leaf
            if (gi < stnl_pkg::MAX_SYMBOLS)
            begin : g_real
                always_ff @(posedge clk)
                begin
                    node_reg[stnl_pkg::TREE_LEAVES + gi] <= leaf[gi];
                end
            end
            else
            begin : g_pad
                always_ff @(posedge clk)
                begin
                    node_reg[stnl_pkg::TREE_LEAVES + gi] <= '0;
                end
            end
        end
        // At most one leaf hits, so an OR of each pair passes it up unchanged.
        for (gi = 1; gi < stnl_pkg::TREE_LEAVES; gi++)
        begin : g_node
            always_ff @(posedge clk)
            begin
                node_reg[gi] <= node_reg[2*gi] | node_reg[2*gi+1];
            end
        end
    endgenerate

    assign root = node_reg[1];

endmodule

/* design/symbol_table_nearest_lookup.sv */
`timescale 1ns / 1ps
// Top level of the nearest-symbol lookup block: control, chain of cells, gather tree.
// Depends on stnl_pkg, stnl_cell and stnl_tree.
//
// The block keeps up to MAX_SYMBOLS symbols sorted by address in a row of
// cells, one entry per cell, and answers floor lookups on them. It works on
// one beat at a time. A clear, a skipped or refused add and a stored add each
// go straight to the finish state after acceptance and give their result beat
// from there: all cells compare the new address at once and every entry that
// sorts after it moves one cell along together. A lookup first waits in the
// look state for the registered OR tree to bring the floor entry up from the
// cells. The result sits in an output register, so a new beat is taken while
// an earlier result is still stalled; a finished item waits for that register
// to empty before it updates the table. Entries beyond the held count are
// never read, so the cells need no clearing after reset and a clear only
// resets the count.
module symbol_table_nearest_lookup
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [1:0]                    req_type,
    input  logic [63:0]                   address_value,
    input  logic [15:0]                   section_index,
    input  logic [7:0]                    info_byte,
    input  logic [31:0]                   name_offset_in,
    input  logic                          name_is_empty,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [2:0]                    status,
    output logic [31:0]                   name_offset_out,
    output logic [63:0]                   match_address,
    output logic [stnl_pkg::COUNT_W-1:0]  entry_count
);

    // Controller states.
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LOOK   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    // Decoded operation held for the item in flight.
    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_SKIP   = 3'd1;
    localparam logic [2:0] OP_FULL   = 3'd2;
    localparam logic [2:0] OP_INSERT = 3'd3;
    localparam logic [2:0] OP_LOOK   = 3'd4;

    localparam logic [stnl_pkg::LAT_W-1:0] LOOK_LAT =
        stnl_pkg::LAT_W'(stnl_pkg::TREE_LEVELS + 1);
    localparam logic [stnl_pkg::COUNT_W-1:0] FULL_COUNT =
        stnl_pkg::COUNT_W'(stnl_pkg::MAX_SYMBOLS);

    logic [1:0]                     state_reg;
    logic [1:0]                     state_next;
    logic [2:0]                     op_reg;
    logic [2:0]                     op_next;
    logic [stnl_pkg::LAT_W-1:0]     lat_reg;
    logic [stnl_pkg::LAT_W-1:0]     lat_next;
    logic [stnl_pkg::COUNT_W-1:0]   count_reg;
    logic [stnl_pkg::COUNT_W-1:0]   count_next;
    logic [stnl_pkg::ADDR_W-1:0]    key_reg;
    logic [stnl_pkg::ADDR_W-1:0]    key_next;
    logic [stnl_pkg::NAME_W-1:0]    name_reg;
    logic [stnl_pkg::NAME_W-1:0]    name_next;

    logic                           rsp_valid_reg;
    logic                           rsp_valid_next;
    logic [2:0]                     status_reg;
    logic [2:0]                     status_next;
    logic [stnl_pkg::NAME_W-1:0]    name_out_reg;
    logic [stnl_pkg::NAME_W-1:0]    name_out_next;
    logic [stnl_pkg::ADDR_W-1:0]    addr_out_reg;
    logic [stnl_pkg::ADDR_W-1:0]    addr_out_next;
    logic [stnl_pkg::COUNT_W-1:0]   count_out_reg;
    logic [stnl_pkg::COUNT_W-1:0]   count_out_next;

    logic                           accept;
    logic                           slot_free;
    logic                           finish;
    logic                           ins_en;
    logic                           eligible;
    logic                           found;

    logic                           cell_le    [stnl_pkg::MAX_SYMBOLS];
    logic                           cell_valid [stnl_pkg::MAX_SYMBOLS];
    logic [stnl_pkg::ADDR_W-1:0]    cell_addr  [stnl_pkg::MAX_SYMBOLS];
    logic [stnl_pkg::NAME_W-1:0]    cell_name  [stnl_pkg::MAX_SYMBOLS];
    stnl_pkg::leaf_t                cell_leaf  [stnl_pkg::MAX_SYMBOLS];
    logic [stnl_pkg::MAX_SYMBOLS-1:0] hit_vec;
    stnl_pkg::leaf_t                root;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid & ~req_stall;
    assign slot_free = ~rsp_valid_reg | ~rsp_stall;
    assign finish    = (state_reg == S_FINISH) & slot_free;
    assign ins_en    = finish & (op_reg == OP_INSERT);
    assign found     = root.hit & ~root.beyond;

    // An add is dropped for an undefined section, an empty name, a file
    // symbol or a zero address, ahead of the table-full test.
    assign eligible = (section_index != 16'd0) & ~name_is_empty &
                      (info_byte[3:0] != stnl_pkg::SYM_TYPE_FILE) &
                      (address_value != 64'd0);

    // The chain of cells. Each cell sees the compare result and entry of
    // its lower neighbour for the shift, and its upper neighbour's compare
    // to decide whether it is the floor.
    genvar gi;
    generate
        for (gi = 0; gi < stnl_pkg::MAX_SYMBOLS; gi++)
        begin : g_cell
            logic                        prev_le;
            logic [stnl_pkg::ADDR_W-1:0] prev_addr;
            logic [stnl_pkg::NAME_W-1:0] prev_name;
            logic                        next_le;
            logic                        next_valid;

            assign cell_valid[gi] = (stnl_pkg::COUNT_W'(gi) < count_reg);
            assign hit_vec[gi]    = cell_leaf[gi].hit;

            if (gi == 0)
            begin : g_first
                assign prev_le   = 1'b1;
                assign prev_addr = key_reg;
                assign prev_name = name_reg;
            end
            else
            begin : g_inner
                assign prev_le   = cell_le[gi-1];
                assign prev_addr = cell_addr[gi-1];
                assign prev_name = cell_name[gi-1];
            end

            if (gi == stnl_pkg::MAX_SYMBOLS - 1)
            begin : g_last
                assign next_le    = 1'b0;
                assign next_valid = 1'b0;
            end
            else
            begin : g_body
                assign next_le    = cell_le[gi+1];
                assign next_valid = cell_valid[gi+1];
            end

            stnl_cell u_cell
            (
                .clk        (clk),
                .key        (key_reg),
                .name_new   (name_reg),
                .ins_en     (ins_en),
                .valid      (cell_valid[gi]),
                .prev_le    (prev_le),
                .prev_addr  (prev_addr),
                .prev_name  (prev_name),
                .next_le    (next_le),
                .next_valid (next_valid),
                .le         (cell_le[gi]),
                .addr       (cell_addr[gi]),
                .name       (cell_name[gi]),
                .leaf       (cell_leaf[gi])
            );
        end
    endgenerate

    stnl_tree u_tree
    (
        .clk  (clk),
        .leaf (cell_leaf),
        .root (root)
    );

    // Controller: take a beat in idle, wait out the tree for a lookup, then
    // apply the item and load the result once the output register is free.
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        lat_next       = lat_reg;
        count_next     = count_reg;
        key_next       = key_reg;
        name_next      = name_reg;
        rsp_valid_next = rsp_valid_reg & rsp_stall;
        status_next    = status_reg;
        name_out_next  = name_out_reg;
        addr_out_next  = addr_out_reg;
        count_out_next = count_out_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    key_next  = address_value;
                    name_next = name_offset_in;
                    lat_next  = LOOK_LAT;
                    case (req_type)
                        stnl_pkg::REQ_CLEAR:
                        begin
                            op_next    = OP_CLEAR;
                            state_next = S_FINISH;
                        end
                        stnl_pkg::REQ_ADD:
                        begin
                            if (!eligible)
                            begin
                                op_next = OP_SKIP;
                            end
                            else if (count_reg == FULL_COUNT)
                            begin
                                op_next = OP_FULL;
                            end
                            else
                            begin
                                op_next = OP_INSERT;
                            end
                            state_next = S_FINISH;
                        end
                        stnl_pkg::REQ_LOOKUP:
                        begin
                            op_next    = OP_LOOK;
                            state_next = S_LOOK;
                        end
                        default:
                        begin
                            op_next    = OP_SKIP;
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_LOOK:
            begin
                if (lat_reg == '0)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    lat_next = lat_reg - 1'b1;
                end
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    name_out_next  = '0;
                    addr_out_next  = '0;
                    case (op_reg)
                        OP_CLEAR:
                        begin
                            count_next  = '0;
                            status_next = stnl_pkg::ST_CLEARED;
                        end
                        OP_FULL:
                        begin
                            status_next = stnl_pkg::ST_FULL;
                        end
                        OP_INSERT:
                        begin
                            count_next  = count_reg + 1'b1;
                            status_next = stnl_pkg::ST_STORED;
                        end
                        OP_LOOK:
                        begin
                            if (found)
                            begin
                                status_next   = stnl_pkg::ST_FOUND;
                                name_out_next = root.name;
                                addr_out_next = root.addr;
                            end
                            else
                            begin
                                status_next = stnl_pkg::ST_NOTFOUND;
                            end
                        end
                        default:
                        begin
                            status_next = stnl_pkg::ST_SKIPPED;
                        end
                    endcase
                    count_out_next = count_next;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_SKIP;
            lat_reg       <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            lat_reg       <= lat_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        name_reg      <= name_next;
        status_reg    <= status_next;
        name_out_reg  <= name_out_next;
        addr_out_reg  <= addr_out_next;
        count_out_reg <= count_out_next;
    end

    assign rsp_valid       = rsp_valid_reg;
    assign status          = status_reg;
    assign name_offset_out = name_out_reg;
    assign match_address   = addr_out_reg;
    assign entry_count     = count_out_reg;

    // The held count never passes the table size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("held count beyond table size");

    // A sorted table has at most one floor cell for any key.
    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOK) |-> $onehot0(hit_vec))
        else $error("more than one cell claims the floor");

    // A stored entry raises the count by exactly one.
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        ins_en |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not advance the count");

    // Only a found result carries an entry, and it needs a non-empty table.
    a_found_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (status_reg != stnl_pkg::ST_FOUND)) |->
        ((name_out_reg == '0) && (addr_out_reg == '0)))
        else $error("payload set on a result that is not a find");

    a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (status_reg == stnl_pkg::ST_FOUND)) |->
        (count_out_reg != '0))
        else $error("find reported on an empty table");

endmodule
